// ===== hw/rtl/tmon_pkg.sv =====
// tmon_pkg: shared types, register indexes and constants of the thermistor monitor
// no dependencies; used by every module in hw/rtl

package tmon_pkg;

    // adc and stuck-sensor constants
    localparam int ADC_BITS = 12;
    localparam logic [11:0] ADC_MASK = (ADC_BITS >= 12) ? 12'hFFF : 12'((1 << ADC_BITS) - 1);
    localparam logic [15:0] STUCK_SAMPLES = 16'd1000;

    // serial divider geometry
    localparam int DIV_NUM_W = 38;
    localparam int DIV_DEN_W = 20;
    localparam logic [5:0] DIV_STEPS = 6'd38;

    // register indexes
    localparam logic [2:0] REG_FILTER_ALPHA   = 3'd0;
    localparam logic [2:0] REG_FIXED_RESISTOR = 3'd1;
    localparam logic [2:0] REG_SUPPLY_COUNTS  = 3'd2;
    localparam logic [2:0] REG_RES_LOW_LIMIT  = 3'd3;
    localparam logic [2:0] REG_RES_HIGH_LIMIT = 3'd4;
    localparam logic [2:0] REG_HIGH_TEMP      = 3'd5;
    localparam logic [2:0] REG_LOW_TEMP       = 3'd6;
    localparam logic [2:0] REG_DEBOUNCE       = 3'd7;

    // range status codes
    localparam logic [1:0] RANGE_NONE = 2'd0;
    localparam logic [1:0] RANGE_LOW  = 2'd1;
    localparam logic [1:0] RANGE_HIGH = 2'd2;

    // segment codes
    localparam logic [2:0] SEG_0 = 3'd0;
    localparam logic [2:0] SEG_1 = 3'd1;
    localparam logic [2:0] SEG_2 = 3'd2;
    localparam logic [2:0] SEG_3 = 3'd3;
    localparam logic [2:0] SEG_4 = 3'd4;

    // segment bounds, kOhm Q.10
    localparam logic [17:0] SEG0_LO = 18'd54938;
    localparam logic [17:0] SEG0_HI = 18'd200704;
    localparam logic [17:0] SEG1_LO = 18'd15027;
    localparam logic [17:0] SEG2_LO = 18'd4261;
    localparam logic [17:0] SEG3_LO = 18'd1487;
    localparam logic [17:0] SEG4_LO = 18'd544;

    // quadratic coefficients times 1e4
    localparam logic signed [18:0] SEG_A [5] = '{19'sd9, 19'sd120, 19'sd1863,
                                                 19'sd21111, 19'sd219600};
    localparam logic signed [20:0] SEG_B [5] = '{-21'sd3874, -21'sd16409, -21'sd69913,
                                                 -21'sd257196, -21'sd886744};
    localparam logic signed [21:0] SEG_C [5] = '{22'sd27585, 22'sd359216, 22'sd751228,
                                                 22'sd1172740, 22'sd1651871};

    // rounding and scaling of the polynomial result
    localparam logic signed [51:0] POLY_HALF = 52'sd327680000;
    localparam logic signed [35:0] TEMP_TOP  = 36'sd40960000;
    localparam logic signed [35:0] TEMP_BOT  = -36'sd20480000;
    // 2^30/625 rounded up; exact quotient for dividends below 2^22
    localparam logic signed [21:0] TEMP_RECIP = 22'sd1717987;

    typedef struct packed {
        logic [16:0]        filter_alpha;
        logic [17:0]        fixed_resistor;
        logic [11:0]        supply_counts;
        logic [17:0]        res_low_limit;
        logic [17:0]        res_high_limit;
        logic signed [12:0] temp_hi_limit;
        logic signed [12:0] temp_lo_limit;
        logic [15:0]        alarm_debounce;
    } cfg_t;

    typedef struct packed {
        logic signed [12:0] temperature_out;
        logic               high_alarm;
        logic               low_alarm;
        logic               sensor_stuck;
        logic [1:0]         range_status;
    } result_t;

endpackage

// ===== hw/rtl/tmon_front.sv =====
// tmon_front: two-entry sample queue in front of the compute engine
// depends on tmon_pkg

module tmon_front
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [11:0] adc_sample,
    output logic        smp_valid,
    input  logic        smp_ready,
    output logic [11:0] smp_data
);

    logic [11:0] slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pull;

    assign full      = (count_reg == 2'd2);
    assign smp_valid = (count_reg != 2'd0);
    assign smp_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pull   = smp_valid && smp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                // unused adc bits dropped on entry
                slot_reg[wr_ptr_reg] <= adc_sample & tmon_pkg::ADC_MASK;
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pull)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pull)
                count_reg <= count_reg + 2'd1;
            else if (do_pull && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== hw/rtl/tmon_div.sv =====
// tmon_div: restoring unsigned divider, one quotient bit per cycle
// depends on tmon_pkg

module tmon_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tmon_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [tmon_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                            done,
    output logic [tmon_pkg::DIV_NUM_W-1:0]  quotient
);

    logic [tmon_pkg::DIV_NUM_W-1:0] quot_reg;
    logic [tmon_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [tmon_pkg::DIV_DEN_W-1:0] den_reg;
    logic [5:0]                     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [tmon_pkg::DIV_DEN_W:0]   rem_sh;
    logic [tmon_pkg::DIV_DEN_W+1:0] trial;

    assign rem_sh   = {rem_reg, quot_reg[tmon_pkg::DIV_NUM_W-1]};
    assign trial    = {1'b0, rem_sh} - {2'b00, den_reg};
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quot_reg <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= tmon_pkg::DIV_STEPS;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!trial[tmon_pkg::DIV_DEN_W+1])
                begin
                    rem_reg  <= trial[tmon_pkg::DIV_DEN_W-1:0];
                    quot_reg <= {quot_reg[tmon_pkg::DIV_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[tmon_pkg::DIV_DEN_W-1:0];
                    quot_reg <= {quot_reg[tmon_pkg::DIV_NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/tmon_back.sv =====
// tmon_back: sequencer for filter, resistance, polynomial and alarms
// depends on tmon_pkg and tmon_div

module tmon_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  tmon_pkg::cfg_t      cfg,
    input  logic                smp_valid,
    output logic                smp_ready,
    input  logic [11:0]         smp_data,
    output logic                res_valid,
    input  logic                res_ready,
    output tmon_pkg::result_t   res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILT, ST_RMUL, ST_RDIV_GO, ST_RDIV, ST_CLAMP, ST_SEG, ST_PAR,
        ST_PPR_GO, ST_PPR, ST_TSCALE, ST_TDIV, ST_ALARM, ST_DONE
    } state_t;

    state_t             state_reg;
    logic               primed_reg;
    logic [19:0]        filt_reg;
    logic [15:0]        stuck_cnt_reg;
    logic               stuck_reg;
    logic [15:0]        high_cnt_reg;
    logic [15:0]        low_cnt_reg;
    logic               high_lat_reg;
    logic               low_lat_reg;
    logic signed [12:0] held_reg;
    logic [1:0]         range_reg;
    logic [19:0]        den_reg;
    logic [17:0]        r_reg;
    logic [2:0]         seg_reg;
    logic signed [31:0] p_reg;
    logic signed [51:0] n_reg;
    logic signed [32:0] op_a_reg;
    logic signed [21:0] op_b_reg;

    logic signed [54:0] prod;
    logic [19:0]        s_val;
    logic signed [20:0] diff;
    logic [16:0]        a_eff;
    logic signed [20:0] filt_step;
    logic signed [21:0] den_raw;
    logic signed [35:0] y_val;
    logic [21:0]        z_val;
    logic [15:0]        high_inc;
    logic [15:0]        low_inc;
    logic               div_start;
    logic [37:0]        div_num;
    logic [19:0]        div_den;
    logic               div_done;
    logic [37:0]        div_quot;

    assign prod      = op_a_reg * op_b_reg;
    assign s_val     = {smp_data, 8'h00};
    assign diff      = $signed({1'b0, s_val}) - $signed({1'b0, filt_reg});
    assign a_eff     = (cfg.filter_alpha > 17'd65536) ? 17'd65536 : cfg.filter_alpha;
    assign filt_step = 21'((prod + 55'sd32768) >>> 16);
    assign den_raw   = $signed({2'b00, cfg.supply_counts, 8'h00}) - $signed({2'b00, filt_reg});
    assign y_val     = n_reg[51:16];
    // offset into the unsigned range, then divided by 16 so only /625 is left
    assign z_val     = 22'((y_val - tmon_pkg::TEMP_BOT) >>> 4);
    assign high_inc  = high_cnt_reg + 16'd1;
    assign low_inc   = low_cnt_reg + 16'd1;

    assign smp_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.temperature_out = held_reg;
    assign res.high_alarm      = high_lat_reg;
    assign res.low_alarm       = low_lat_reg;
    assign res.sensor_stuck    = stuck_reg;
    assign res.range_status    = range_reg;

    assign div_start = (state_reg == ST_RDIV_GO);
    assign div_num   = prod[37:0];
    assign div_den   = den_reg;

    tmon_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            primed_reg    <= 1'b0;
            filt_reg      <= '0;
            stuck_cnt_reg <= '0;
            stuck_reg     <= 1'b0;
            high_cnt_reg  <= '0;
            low_cnt_reg   <= '0;
            high_lat_reg  <= 1'b0;
            low_lat_reg   <= 1'b0;
            held_reg      <= '0;
            range_reg     <= tmon_pkg::RANGE_NONE;
            den_reg       <= '0;
            r_reg         <= '0;
            seg_reg       <= tmon_pkg::SEG_0;
            p_reg         <= '0;
            n_reg         <= '0;
            op_a_reg      <= '0;
            op_b_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (smp_valid)
                    begin
                        if (!primed_reg)
                        begin
                            filt_reg   <= s_val;
                            primed_reg <= 1'b1;
                            state_reg  <= ST_RMUL;
                        end
                        else
                        begin
                            // stuck check against the old filter value
                            if ((diff > -21'sd256) && (diff < 21'sd256))
                            begin
                                if (stuck_cnt_reg != 16'hFFFF)
                                begin
                                    stuck_cnt_reg <= stuck_cnt_reg + 16'd1;
                                    if ((stuck_cnt_reg + 16'd1) >= tmon_pkg::STUCK_SAMPLES)
                                        stuck_reg <= 1'b1;
                                end
                                else if (stuck_cnt_reg >= tmon_pkg::STUCK_SAMPLES)
                                    stuck_reg <= 1'b1;
                            end
                            else
                            begin
                                stuck_cnt_reg <= '0;
                                stuck_reg     <= 1'b0;
                            end
                            op_a_reg  <= $signed({16'd0, a_eff});
                            op_b_reg  <= 22'(diff);
                            state_reg <= ST_FILT;
                        end
                    end
                end
                ST_FILT:
                begin
                    // f + round(alpha * (s - f) / 2^16)
                    filt_reg  <= 20'($signed({1'b0, filt_reg}) + filt_step);
                    state_reg <= ST_RMUL;
                end
                ST_RMUL:
                begin
                    op_a_reg  <= $signed({15'd0, cfg.fixed_resistor});
                    op_b_reg  <= $signed({2'b00, filt_reg});
                    den_reg   <= (den_raw < 22'sd256) ? 20'd256 : den_raw[19:0];
                    state_reg <= ST_RDIV_GO;
                end
                ST_RDIV_GO:
                    state_reg <= ST_RDIV;
                ST_RDIV:
                    if (div_done)
                        state_reg <= ST_CLAMP;
                ST_CLAMP:
                begin
                    if (div_quot < {20'd0, cfg.res_low_limit})
                    begin
                        r_reg     <= cfg.res_low_limit;
                        range_reg <= tmon_pkg::RANGE_LOW;
                    end
                    else if (div_quot > {20'd0, cfg.res_high_limit})
                    begin
                        r_reg     <= cfg.res_high_limit;
                        range_reg <= tmon_pkg::RANGE_HIGH;
                    end
                    else
                        r_reg <= div_quot[17:0];
                    state_reg <= ST_SEG;
                end
                ST_SEG:
                begin
                    op_b_reg  <= $signed({4'd0, r_reg});
                    state_reg <= ST_PAR;
                    if ((r_reg >= tmon_pkg::SEG0_LO) && (r_reg <= tmon_pkg::SEG0_HI))
                    begin
                        seg_reg  <= tmon_pkg::SEG_0;
                        op_a_reg <= 33'(tmon_pkg::SEG_A[0]);
                    end
                    else if (r_reg >= tmon_pkg::SEG1_LO)
                    begin
                        seg_reg  <= tmon_pkg::SEG_1;
                        op_a_reg <= 33'(tmon_pkg::SEG_A[1]);
                    end
                    else if (r_reg >= tmon_pkg::SEG2_LO)
                    begin
                        seg_reg  <= tmon_pkg::SEG_2;
                        op_a_reg <= 33'(tmon_pkg::SEG_A[2]);
                    end
                    else if (r_reg >= tmon_pkg::SEG3_LO)
                    begin
                        seg_reg  <= tmon_pkg::SEG_3;
                        op_a_reg <= 33'(tmon_pkg::SEG_A[3]);
                    end
                    else if (r_reg >= tmon_pkg::SEG4_LO)
                    begin
                        seg_reg  <= tmon_pkg::SEG_4;
                        op_a_reg <= 33'(tmon_pkg::SEG_A[4]);
                    end
                    else
                        state_reg <= ST_ALARM;  // below table, keep old temperature
                end
                ST_PAR:
                begin
                    p_reg <= prod[31:0] + (32'(tmon_pkg::SEG_B[seg_reg]) <<< 10);
                    state_reg <= ST_PPR_GO;
                end
                ST_PPR_GO:
                begin
                    op_a_reg  <= 33'(p_reg);
                    state_reg <= ST_PPR;
                end
                ST_PPR:
                begin
                    n_reg <= prod[51:0] + (52'(tmon_pkg::SEG_C[seg_reg]) <<< 20)
                             + tmon_pkg::POLY_HALF;
                    state_reg <= ST_TSCALE;
                end
                ST_TSCALE:
                begin
                    if (y_val >= tmon_pkg::TEMP_TOP)
                    begin
                        held_reg  <= 13'sd4095;
                        state_reg <= ST_ALARM;
                    end
                    else if (y_val < tmon_pkg::TEMP_BOT)
                    begin
                        held_reg  <= -13'sd2048;
                        state_reg <= ST_ALARM;
                    end
                    else
                    begin
                        // divide by 625 as a reciprocal multiply
                        op_a_reg  <= $signed({11'd0, z_val});
                        op_b_reg  <= tmon_pkg::TEMP_RECIP;
                        state_reg <= ST_TDIV;
                    end
                end
                ST_TDIV:
                begin
                    held_reg  <= 13'(prod[42:30] - 13'd2048);
                    state_reg <= ST_ALARM;
                end
                ST_ALARM:
                begin
                    if ((held_reg >= cfg.temp_hi_limit) && !high_lat_reg)
                    begin
                        if (high_inc >= cfg.alarm_debounce)
                        begin
                            high_lat_reg <= 1'b1;
                            high_cnt_reg <= '0;
                        end
                        else
                            high_cnt_reg <= high_inc;
                    end
                    else
                        high_cnt_reg <= '0;
                    if ((held_reg <= cfg.temp_lo_limit) && !low_lat_reg)
                    begin
                        if (low_inc >= cfg.alarm_debounce)
                        begin
                            low_lat_reg <= 1'b1;
                            low_cnt_reg <= '0;
                        end
                        else
                            low_cnt_reg <= low_inc;
                    end
                    else
                        low_cnt_reg <= '0;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                    if (res_ready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/thermistor_temperature_monitor.sv =====
// thermistor_temperature_monitor: top level with config registers and result register
// depends on tmon_pkg, tmon_front, tmon_back (which uses tmon_div)

// One adc sample of an ntc divider in, one result out. Samples are transferred
// in with push/full into a two-entry queue; a sequencer takes them one at a
// time, low-pass filters the sample (the first one after reset loads the filter),
// derives the divider resistance through a 38-step serial divider, clamps it,
// evaluates a five-segment quadratic on a shared 33x22 multiplier and scales
// the result to 1/16 degree C with a reciprocal multiply on the same multiplier,
// then updates the debounced alarms. The first sample after reset skips the
// filter step, a saturated temperature skips the scaling multiply, and a
// resistance below the bottom segment skips the polynomial and keeps the
// previous temperature. Results sit in a one-entry output register read with
// empty/pop, so the sequencer starts on the next queued sample as soon as the
// result is handed over. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while no sample is in flight, as the block itself
// does not enforce this. Writes take effect on the next clock.

module thermistor_temperature_monitor
(
    input  logic               clk,
    input  logic               rst_n,
    // sample input
    input  logic               push,
    output logic               full,
    input  logic [11:0]        adc_sample,
    // result output
    output logic               empty,
    input  logic               pop,
    output logic signed [12:0] temperature_out,
    output logic               high_alarm,
    output logic               low_alarm,
    output logic               sensor_stuck,
    output logic [1:0]         range_status,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [17:0]        cfg_data
);

    tmon_pkg::cfg_t    cfg_reg;
    tmon_pkg::result_t out_reg;
    logic              out_valid_reg;
    tmon_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;
    logic              smp_valid;
    logic              smp_ready;
    logic [11:0]       smp_data;

    // config registers, reset to their documented defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha    <= 17'd6554;
            cfg_reg.fixed_resistor  <= 18'd10240;
            cfg_reg.supply_counts   <= 12'd4095;
            cfg_reg.res_low_limit   <= 18'd544;
            cfg_reg.res_high_limit  <= 18'd200704;
            cfg_reg.temp_hi_limit   <= 13'sd1600;
            cfg_reg.temp_lo_limit   <= -13'sd640;
            cfg_reg.alarm_debounce  <= 16'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tmon_pkg::REG_FILTER_ALPHA:   cfg_reg.filter_alpha    <= cfg_data[16:0];
                tmon_pkg::REG_FIXED_RESISTOR: cfg_reg.fixed_resistor  <= cfg_data;
                tmon_pkg::REG_SUPPLY_COUNTS:  cfg_reg.supply_counts   <= cfg_data[11:0];
                tmon_pkg::REG_RES_LOW_LIMIT:  cfg_reg.res_low_limit   <= cfg_data;
                tmon_pkg::REG_RES_HIGH_LIMIT: cfg_reg.res_high_limit  <= cfg_data;
                tmon_pkg::REG_HIGH_TEMP:      cfg_reg.temp_hi_limit   <= $signed(cfg_data[12:0]);
                tmon_pkg::REG_LOW_TEMP:       cfg_reg.temp_lo_limit   <= $signed(cfg_data[12:0]);
                tmon_pkg::REG_DEBOUNCE:       cfg_reg.alarm_debounce  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front: sample queue
    tmon_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .adc_sample (adc_sample),
        .smp_valid  (smp_valid),
        .smp_ready  (smp_ready),
        .smp_data   (smp_data)
    );

    // back: compute sequencer
    tmon_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .smp_valid (smp_valid),
        .smp_ready (smp_ready),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: refilled in the same cycle the old result is popped
    assign res_ready = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty           = !out_valid_reg;
    assign temperature_out = out_reg.temperature_out;
    assign high_alarm      = out_reg.high_alarm;
    assign low_alarm       = out_reg.low_alarm;
    assign sensor_stuck    = out_reg.sensor_stuck;
    assign range_status    = out_reg.range_status;

endmodule
